// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file qdec_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is also checked across reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/qdec_pkg.sv =====
package qdec_pkg;

   localparam int unsigned QDEC_COUNT_WIDTH = 32;
   localparam logic [31:0] QDEC_DELAY_RESET = 32'd50000;

   // Stream payload widths, whole bytes.
   localparam int unsigned QDEC_REQ_TDATA_W = 40;
   localparam int unsigned QDEC_RSP_TDATA_W = 40;

   // x4 step per transition code {B, A, prevB, prevA}.
   // Both lines changing counts as a skipped state: +2 or -2.
   localparam logic signed [2:0] QDEC_STEP_TABLE [16] = '{
       3'sd0,  3'sd1, -3'sd1,  3'sd2,
      -3'sd1,  3'sd0, -3'sd2,  3'sd1,
       3'sd1, -3'sd2,  3'sd0, -3'sd1,
       3'sd2, -3'sd1,  3'sd1,  3'sd0
   };

endpackage

// ===== hw/rtl/qdec_debounce.sv =====
module qdec_debounce
   import qdec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        sample_en,
   input  logic        button_raw,
   input  logic [31:0] time_us,
   input  logic [31:0] delay_us,
   output logic        stable_button
);

   logic        stable_ff, stable_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] elapsed;
   logic        take_change;

   // Wrapping elapsed time since the last accepted change.
   assign elapsed     = time_us - last_time_ff;
   assign take_change = sample_en && (button_raw != stable_ff) && (elapsed > delay_us);

   always_comb begin
      stable_in    = stable_ff;
      last_time_in = last_time_ff;
      if (take_change) begin
         stable_in    = button_raw;
         last_time_in = time_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= 1'b0;
         last_time_ff <= '0;
      end else begin
         stable_ff    <= stable_in;
         last_time_ff <= last_time_in;
      end
   end

   assign stable_button = stable_ff;

endmodule

// ===== hw/rtl/quadrature_decoder_with_button_debounce_top.sv =====
// One channel of an x4 quadrature decoder with a debounced push button. Each
// req transaction carries one sample of the A and B lines and the button (all
// active high, already synchronized) plus a free-running microsecond
// timestamp; each sample yields exactly one rsp transaction with the wrapping
// signed position count and the debounced button state after that sample. A
// transition where both lines flip counts as a skipped state (+2 or -2). A
// button change is taken only when the wrapping time since the last taken
// change is strictly greater than the delay in the CSR (reset 50000 us; all
// ones blocks every change). Throughput is one sample per clock: the decode
// add and the debounce compare sit between the sample and the state registers,
// which are also the result register, so a new sample enters whenever the
// result slot is empty or being drained. Write the CSR only while idle.
// Second encoder: instantiate a second copy.
module quadrature_decoder_with_button_debounce_top
   import qdec_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = QDEC_COUNT_WIDTH  // 8..64
)(
   input  logic                        clock,
   input  logic                        reset,

   // Sample stream.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [0] line_a_active, [1] line_b_active, [2] button_active,
   // [34:3] time_us, [39:35] zero
   input  logic [QDEC_REQ_TDATA_W-1:0] req_tdata,

   // Result stream.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] position_count (signed), [32] button_pressed, [39:33] zero
   output logic [QDEC_RSP_TDATA_W-1:0] rsp_tdata,

   // debounce_delay_us write channel.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [31:0]                 csr_data
);

   logic                          req_fire;
   logic                          line_a, line_b, button_raw;
   logic [31:0]                   time_us;

   logic [1:0]                    prev_ab_ff, prev_ab_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [31:0]                   delay_ff, delay_in;
   logic signed [2:0]             step;
   logic                          stable_button;
   logic signed [31:0]            position_count;

   assign line_a     = req_tdata[0];
   assign line_b     = req_tdata[1];
   assign button_raw = req_tdata[2];
   assign time_us    = req_tdata[34:3];

   // Result slot frees up when empty or when the current result is taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Transition code {B, A, prevB, prevA} picks the step.
   assign step = QDEC_STEP_TABLE[{line_b, line_a, prev_ab_ff}];

   always_comb begin
      prev_ab_in   = prev_ab_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      delay_in     = delay_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         prev_ab_in   = {line_b, line_a};
         count_in     = count_ff + COUNT_WIDTH'(step);  // sign-extended step, wraps
         rsp_valid_in = 1'b1;
      end
      if (csr_valid) begin
         delay_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         delay_ff     <= QDEC_DELAY_RESET;
      end else begin
         prev_ab_ff   <= prev_ab_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         delay_ff     <= delay_in;
      end
   end

   qdec_debounce u_debounce (
      .clock         (clock),
      .reset         (reset),
      .sample_en     (req_fire),
      .button_raw    (button_raw),
      .time_us       (time_us),
      .delay_us      (delay_ff),
      .stable_button (stable_button)
   );

   // Sign-extend or truncate the count to the 32-bit result field.
   assign position_count = 32'($signed(count_ff));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, stable_button, position_count};

endmodule

// ===== hw/rtl/qdec_checker.sv =====
`include "assert_macros.svh"

module qdec_checker
   import qdec_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [QDEC_REQ_TDATA_W-1:0] req_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [QDEC_RSP_TDATA_W-1:0] rsp_tdata,
   input logic                        csr_valid,
   input logic                        csr_ready,
   input logic [31:0]                 csr_data
);

   `ASSERT_CLK(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled rsp transaction changed")

   `ASSERT_CLK_RST(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready, "req stalled with empty result slot")

   `ASSERT_CLK_RST(a_req_makes_rsp, clock, reset, req_tvalid && req_tready |=> rsp_tvalid, "req transaction produced no rsp")

   `ASSERT_CLK_RST(a_count_needs_req, clock, reset, !(req_tvalid && req_tready) |=> $stable(rsp_tdata[32:0]), "result changed without req transaction")

endmodule

bind quadrature_decoder_with_button_debounce_top qdec_checker u_qdec_checker (.*);

// ===== sim/quadrature_decoder_with_button_debounce_top_tb.sv =====
module quadrature_decoder_with_button_debounce_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qdec_pkg::*;

   // Cycles with no transaction on any channel before the run is abandoned.
   // The longest deliberate hold-off below is the LONG_HOLD receiver stall.
   localparam int QUIET_LIMIT    = 2000;
   localparam int PHASE_SAMPLES  = 220;
   localparam int LONG_HOLD      = 300;
   localparam int TAIL_CYCLES    = 5;

   // Directed walk: together with the reset value of the previous AB pair, this
   // sequence of {B,A} pairs produces every one of the 16 transition codes once.
   localparam logic [1:0]  DIR_AB  [16] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
                                            2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
   localparam logic        DIR_BTN [16] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                            1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
   // Button timestamps against the reset delay of 50000 us: below, equal to and
   // one past the delay, then across the 32-bit wrap of the timestamp.
   localparam logic [31:0] DIR_US  [16] = '{32'd0, 32'd10, 32'd50000, 32'd50001,
                                            32'd50002, 32'd100001, 32'd100002, 32'hFFFF_FFFE,
                                            32'hFFFF_FFFF, 32'h0000_C34F, 32'h0000_C350,
                                            32'h0001_2345, 32'h0001_86A0, 32'h7FFF_FFFF,
                                            32'h8000_0000, 32'hAAAA_5555};

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic               pressed;
   } qdec_result_type;

   // Tracks decoder state from accepted samples and holds the expected
   // results in order until the rsp side delivers them.
   class qdec_scoreboard;
      logic [31:0]        delay_us;
      logic [1:0]         prev_ab;        // bit0 = A, bit1 = B
      logic signed [31:0] position;
      logic               raw_btn;
      logic               stable_btn;
      logic [31:0]        last_change_us;
      qdec_result_type    pending[$];
      int                 errors;

      function new();
         delay_us       = QDEC_DELAY_RESET;
         prev_ab        = 2'b00;
         position       = '0;
         raw_btn        = 1'b0;
         stable_btn     = 1'b0;
         last_change_us = '0;
         errors         = 0;
      endfunction

      function void set_delay(logic [31:0] value);
         delay_us = value;
      endfunction

      // Position along the forward cycle 00 -> 10 -> 11 -> 01 ({B,A}).
      static function logic [1:0] phase_of(logic a, logic b);
         return {a, a ^ b};
      endfunction

      function void note_sample(logic [QDEC_REQ_TDATA_W-1:0] tdata);
         logic            a, b;
         logic [31:0]     now_us, elapsed;
         logic [1:0]      new_phase, phase_step;
         qdec_result_type res;
         a          = tdata[0];
         b          = tdata[1];
         raw_btn    = tdata[2];
         now_us     = tdata[34:3];
         new_phase  = phase_of(a, b);
         phase_step = new_phase - phase_of(prev_ab[0], prev_ab[1]);
         case (phase_step)
            2'd1: position = position + 32'sd1;
            2'd3: position = position - 32'sd1;
            // skipped state: sign depends on where the pair landed
            2'd2: position = new_phase[0] ? position - 32'sd2 : position + 32'sd2;
            default: ;
         endcase
         prev_ab = {b, a};
         elapsed = now_us - last_change_us;
         if (raw_btn != stable_btn && elapsed > delay_us) begin
            stable_btn     = raw_btn;
            last_change_us = now_us;
         end
         res.position = position;
         res.pressed  = stable_btn;
         pending.push_back(res);
      endfunction

      function void check_result(logic [QDEC_RSP_TDATA_W-1:0] tdata);
         qdec_result_type want;
         if (pending.size() == 0) begin
            $error("rsp transaction with no sample pending: tdata=%h", tdata);
            errors++;
         end else begin
            want = pending.pop_front();
            if (tdata[31:0] !== want.position) begin
               $error("position_count: expected %0d, actual %0d",
                      want.position, $signed(tdata[31:0]));
               errors++;
            end
            if (tdata[32] !== want.pressed) begin
               $error("button_pressed: expected %0b, actual %0b", want.pressed, tdata[32]);
               errors++;
            end
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   // [0] line_a_active, [1] line_b_active, [2] button_active, [34:3] time_us
   logic [QDEC_REQ_TDATA_W-1:0] req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   // [31:0] position_count, [32] button_pressed
   logic [QDEC_RSP_TDATA_W-1:0] rsp_tdata;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [31:0]                 csr_data;

   qdec_scoreboard sb = new();

   // Idling knobs, percent of cycles, changed between phases.
   int send_idle_pct;
   int rsp_stall_pct;
   // Long receiver hold-off, counted down by the receiver process itself.
   int rsp_hold_cycles;
   int quiet_cycles;

   // Stimulus state: walk position, direction, button level, time, delay.
   logic [1:0]  stim_phase;
   logic        stim_fwd;
   logic        stim_btn;
   logic [31:0] stim_time;
   logic [31:0] stim_delay;

   quadrature_decoder_with_button_debounce_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: every handshake is observed at the rising edge. A sample feeds
   // the prediction, a result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_delay(csr_data);
         if (req_tvalid && req_tready) sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // Watchdog: counts cycles in which no channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random back-pressure, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready = 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // One sample transaction, with random idle cycles in front of it. Valid
   // stays high on return so back-to-back samples keep it asserted.
   task automatic send_sample(input logic a, input logic b, input logic btn,
                              input logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {5'b0, t, btn, b, a};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stop offering samples and wait for every expected result.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   // The delay register is only written once the block has gone idle.
   task automatic write_delay(input logic [31:0] value);
      wait_drained();
      stim_delay = value;
      csr_valid  = 1'b1;
      csr_data   = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid  = 1'b0;
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 83; rsp_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  rsp_stall_pct = 83; end
         default:       begin send_idle_pct = 20; rsp_stall_pct = 20; end
      endcase
   endtask

   // Mostly legal single steps in a drifting direction, with holds, skipped
   // states and arbitrary pairs mixed in. Time steps are scaled to the delay
   // so the debounce decision lands on both sides of the threshold; some
   // timestamps jump anywhere, which also wraps the counter.
   task automatic send_random_sample();
      int unsigned pick;
      logic [31:0] step_us;
      pick = $urandom_range(99);
      if (pick < 80) begin
         if ($urandom_range(19) == 0) stim_fwd = !stim_fwd;
         stim_phase = stim_fwd ? stim_phase + 2'd1 : stim_phase - 2'd1;
      end else if (pick >= 88) begin
         if (pick < 95) stim_phase = stim_phase + 2'd2;
         else stim_phase = 2'($urandom_range(3));
      end

      pick    = $urandom_range(99);
      step_us = '0;
      if (pick < 30) step_us = $urandom_range(3);
      else if (pick < 55) step_us = stim_delay + $urandom_range(2) - 1;
      else if (pick < 80) step_us = $urandom_range(stim_delay);
      else if (pick < 90) step_us = $urandom;
      if (pick < 90) stim_time = stim_time + step_us;
      else stim_time = $urandom;

      // bouncing contact: flips often, holds in between
      if ($urandom_range(9) < 3) stim_btn = !stim_btn;

      send_sample(stim_phase[1], stim_phase[1] ^ stim_phase[0], stim_btn, stim_time);
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = 0;
      quiet_cycles    = 0;
      stim_phase      = 2'd0;
      stim_fwd        = 1'b1;
      stim_btn        = 1'b0;
      stim_time       = '0;
      stim_delay      = QDEC_DELAY_RESET;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: all 16 transition codes, debounce at and around the reset
      // delay, and a button change accepted across the timestamp wrap.
      for (int i = 0; i < 16; i++) begin
         send_sample(DIR_AB[i][0], DIR_AB[i][1], DIR_BTN[i], DIR_US[i]);
      end

      // All-ones delay: no change may ever be taken, however long the gap.
      write_delay(32'hFFFF_FFFF);
      send_sample(1'b0, 1'b0, 1'b0, 32'h2AAA_5555);
      send_sample(1'b0, 1'b0, 1'b0, 32'hAAAA_5554);
      send_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);

      // Zero delay: same timestamp as the last change is still blocked,
      // one microsecond later is enough.
      write_delay(32'd0);
      send_sample(1'b0, 1'b0, 1'b0, 32'hAAAA_5555);
      send_sample(1'b0, 1'b0, 1'b0, 32'hAAAA_5556);
      send_sample(1'b0, 1'b0, 1'b1, 32'hAAAA_5556);

      // Directed walk ended on {B,A} = 00, which is phase 0.
      stim_phase = 2'd0;
      stim_time  = 32'hAAAA_5556;
      stim_btn   = 1'b1;

      // Random phases: each one picks a delay setting and an idling pattern.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_delay(32'd100);
            1: write_delay(32'd0);
            2: write_delay($urandom_range(2000, 1));
            3: write_delay(32'hFFFF_FFFF);
            4: write_delay($urandom);
            5: write_delay(32'hFFFF_FFFE);
            6: write_delay(32'd1);
            default: write_delay(QDEC_DELAY_RESET);
         endcase
         set_idle_mode(idle_mode_type'(ph % 4));
         // Receiver holds off while samples keep coming, so the result slot
         // fills and req_tready has to drop.
         if (ph == 0) rsp_hold_cycles = LONG_HOLD;
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            // sender pauses mid-phase until the block has fully drained
            if (ph == 2 && n == PHASE_SAMPLES / 2) wait_drained();
            send_random_sample();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/qdec_pkg.sv
hw/rtl/qdec_debounce.sv
hw/rtl/quadrature_decoder_with_button_debounce_top.sv
hw/rtl/qdec_checker.sv
sim/quadrature_decoder_with_button_debounce_top_tb.sv
